@@ hdl/jsu_pkg.sv @@
// shared types and constants of the json string unescaper
`timescale 1ns / 1ps
package jsu_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW = 9;
  localparam int unsigned CodeW = 16;
  localparam int unsigned KindW = 2;

  localparam logic [LenW-1:0] MaxOutReset = 9'd255;

  localparam int unsigned CmdDepthDefault = 4;
  localparam int unsigned OutDepthDefault = 4;

  // result kinds
  localparam logic [KindW-1:0] KIND_DATA = 2'd0;
  localparam logic [KindW-1:0] KIND_DONE = 2'd1;
  localparam logic [KindW-1:0] KIND_NOTSTR = 2'd2;
  localparam logic [KindW-1:0] KIND_UNTERM = 2'd3;

  localparam logic [CodeW-1:0] CP_REPLACEMENT = 16'hFFFD;
  localparam logic [CodeW-1:0] CP_TWO_BYTE = 16'h0080;
  localparam logic [CodeW-1:0] CP_THREE_BYTE = 16'h0800;

  // what follows the optional code point in a command
  typedef enum logic [2:0] {
    TAIL_NONE,
    TAIL_RAW,
    TAIL_DONE,
    TAIL_UNTERM,
    TAIL_NOTSTR,
    TAIL_START
  } tail_e;

  typedef struct packed {
    logic             has_code;
    logic [CodeW-1:0] code;
    tail_e            tail;
    logic [ByteW-1:0] tail_byte;
  } cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] out_byte;
    logic [LenW-1:0]  out_length;
    logic             last;
  } result_t;

endpackage

@@ hdl/json_string_unescape.sv @@
// top level of the json string unescaper
//
// Input is a queue: a text word is taken when push is high and full is low,
// one word per cycle. Results come out of a queue: the oldest result sits on
// kind_o, out_byte_o, out_length_o and last_o while empty is low and leaves
// when pop is high. A front stage tracks the string phase and decodes escapes
// into commands; a command queue feeds a back stage that applies the output
// limit and writes at most one result per cycle, while the result queue is
// not full. Throughput: one word per cycle while each word gives at most one
// result; a word that gives several results (at most 4, on a \u escape cut
// short by a non-hex byte or by end of text) holds the back stage until all
// are written, and the command queue absorbs that. Words with no result
// (whitespace, backslash, hex digits) are taken at the same rate. When the
// receiver stalls, results wait in the result queue and then the command
// queue fills, raising full.
// The limit register is written through cfg_valid_i/cfg_data_i, always ready.
// Reset empties both queues, returns to idle and sets the limit to 255.
`timescale 1ns / 1ps
module json_string_unescape import jsu_pkg::*; #(
  parameter int unsigned CmdDepth = CmdDepthDefault,
  parameter int unsigned OutDepth = OutDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [ByteW-1:0] text_byte_i,
  output logic             empty,
  input  logic             pop,
  output logic [KindW-1:0] kind_o,
  output logic [ByteW-1:0] out_byte_o,
  output logic [LenW-1:0]  out_length_o,
  output logic             last_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LenW-1:0]  cfg_data_i
);

  logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t    cmd_wr, cmd_rd;
  logic    res_push, res_full;
  result_t res_wr, res_rd;

  assign cfg_ready_o = 1'b1;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .text_byte_i (text_byte_i),
    .full_o      (full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_wr),
    .cmd_full_i  (cmd_full)
  );

  jsu_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_push),
    .wr_data_i (cmd_wr),
    .full_o    (cmd_full),
    .rd_en_i   (cmd_pop),
    .rd_data_o (cmd_rd),
    .empty_o   (cmd_empty)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_wr),
    .res_full_i  (res_full)
  );

  jsu_fifo #(
    .Width ($bits(result_t)),
    .Depth (OutDepth)
  ) u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_push),
    .wr_data_i (res_wr),
    .full_o    (res_full),
    .rd_en_i   (pop),
    .rd_data_o (res_rd),
    .empty_o   (empty)
  );

  assign kind_o = res_rd.kind;
  assign out_byte_o = res_rd.out_byte;
  assign out_length_o = res_rd.out_length;
  assign last_o = res_rd.last;

endmodule

@@ hdl/jsu_fifo.sv @@
// small register queue used between the stages and at the result side
`timescale 1ns / 1ps
module jsu_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o = (count_q == DepthCnt);
  assign empty_o = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr = wr_en_i && !full_o;
  assign do_rd = rd_en_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ hdl/jsu_front.sv @@
// front stage: string phase tracking and escape decoding into commands
`timescale 1ns / 1ps
module jsu_front import jsu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [ByteW-1:0] text_byte_i,
  output logic             full_o,
  output logic             cmd_push_o,
  output cmd_t             cmd_o,
  input  logic             cmd_full_i
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_STR = 2'd1;
  localparam logic [1:0] PH_ESC = 2'd2;
  localparam logic [1:0] PH_HEX = 2'd3;

  localparam logic [ByteW-1:0] CH_NUL = 8'h00;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_TAB = 8'h09;
  localparam logic [ByteW-1:0] CH_CR = 8'h0D;
  localparam logic [ByteW-1:0] CH_QUOTE = 8'h22;
  localparam logic [ByteW-1:0] CH_BSLASH = 8'h5C;
  localparam logic [ByteW-1:0] CH_U = 8'h75;

  logic [1:0]       phase_q, phase_d;
  logic [CodeW-1:0] code_q, code_d;
  logic [1:0]       digits_q, digits_d;
  logic             accept;
  logic             hex_ok;
  logic [3:0]       hex_val;
  logic [CodeW-1:0] code_next;
  cmd_t             cmd;

  function automatic tail_e string_tail(input logic [ByteW-1:0] b);
    tail_e t;
    if (b == CH_NUL) begin
      t = TAIL_UNTERM;
    end else if (b == CH_QUOTE) begin
      t = TAIL_DONE;
    end else if (b == CH_BSLASH) begin
      t = TAIL_NONE;
    end else begin
      t = TAIL_RAW;
    end
    return t;
  endfunction

  function automatic logic [1:0] string_phase(input logic [ByteW-1:0] b);
    logic [1:0] p;
    if (b == CH_NUL || b == CH_QUOTE) begin
      p = PH_IDLE;
    end else if (b == CH_BSLASH) begin
      p = PH_ESC;
    end else begin
      p = PH_STR;
    end
    return p;
  endfunction

  function automatic logic [ByteW-1:0] escape_map(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] m;
    case (b)
      8'h6E:   m = 8'h0A;
      8'h72:   m = 8'h0D;
      8'h74:   m = 8'h09;
      8'h62:   m = 8'h08;
      8'h66:   m = 8'h0C;
      default: m = b;
    endcase
    return m;
  endfunction

  assign accept = push_i && !cmd_full_i;
  assign full_o = cmd_full_i;

  always_comb begin
    hex_ok = 1'b1;
    hex_val = text_byte_i[3:0];
    if (text_byte_i >= 8'h30 && text_byte_i <= 8'h39) begin
      hex_val = text_byte_i[3:0];
    end else if ((text_byte_i >= 8'h61 && text_byte_i <= 8'h66) ||
                 (text_byte_i >= 8'h41 && text_byte_i <= 8'h46)) begin
      hex_val = text_byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign code_next = {code_q[CodeW-5:0], hex_val};

  always_comb begin
    phase_d = phase_q;
    code_d = code_q;
    digits_d = digits_q;
    cmd.has_code = 1'b0;
    cmd.code = code_q;
    cmd.tail = TAIL_NONE;
    cmd.tail_byte = text_byte_i;
    unique case (phase_q)
      PH_IDLE: begin
        if (text_byte_i == CH_SPACE ||
            (text_byte_i >= CH_TAB && text_byte_i <= CH_CR)) begin
          cmd.tail = TAIL_NONE;
        end else if (text_byte_i == CH_QUOTE) begin
          cmd.tail = TAIL_START;
          phase_d = PH_STR;
        end else begin
          cmd.tail = TAIL_NOTSTR;
        end
      end
      PH_STR: begin
        cmd.tail = string_tail(text_byte_i);
        phase_d = string_phase(text_byte_i);
      end
      PH_ESC: begin
        if (text_byte_i == CH_NUL) begin
          cmd.tail = TAIL_UNTERM;
          phase_d = PH_IDLE;
        end else if (text_byte_i == CH_U) begin
          code_d = '0;
          digits_d = '0;
          phase_d = PH_HEX;
        end else begin
          cmd.tail = TAIL_RAW;
          cmd.tail_byte = escape_map(text_byte_i);
          phase_d = PH_STR;
        end
      end
      PH_HEX: begin
        if (text_byte_i == CH_NUL) begin
          // digits so far go out, then the string is cut off
          cmd.has_code = 1'b1;
          cmd.tail = TAIL_UNTERM;
          phase_d = PH_IDLE;
        end else if (!hex_ok) begin
          // replacement character, then the byte handled as in the string
          cmd.has_code = 1'b1;
          cmd.code = CP_REPLACEMENT;
          cmd.tail = string_tail(text_byte_i);
          phase_d = string_phase(text_byte_i);
        end else begin
          code_d = code_next;
          if (digits_q == 2'd3) begin
            cmd.has_code = 1'b1;
            cmd.code = code_next;
            digits_d = '0;
            phase_d = PH_STR;
          end else begin
            digits_d = digits_q + 2'd1;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  assign cmd_o = cmd;
  assign cmd_push_o = accept && (cmd.has_code || cmd.tail != TAIL_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      code_q <= '0;
      digits_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      code_q <= code_d;
      digits_q <= digits_d;
    end
  end

endmodule

@@ hdl/jsu_back.sv @@
// back stage: utf-8 encoding, output limit and result generation
`timescale 1ns / 1ps
module jsu_back import jsu_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic [LenW-1:0] cfg_data_i,
  input  logic            cmd_valid_i,
  input  cmd_t            cmd_i,
  output logic            cmd_pop_o,
  output logic            res_push_o,
  output result_t         res_o,
  input  logic            res_full_i
);

  logic [LenW-1:0] max_q;
  logic [LenW-1:0] wc_q, wc_d;
  logic [1:0]      step_q, step_d;
  logic [1:0]      nc_q;
  logic            te_q;
  logic [1:0]      natural_n;
  logic            fits;
  logic [1:0]      nc_first, nc;
  logic            te_first, te;
  logic            go, emit_code, emit_tail, last, finish;
  logic [LenW:0]   wc_ext;
  logic [ByteW-1:0] code_byte;
  result_t         res;

  assign wc_ext = {1'b0, wc_q};

  always_comb begin
    if (!cmd_i.has_code) begin
      natural_n = 2'd0;
    end else if (cmd_i.code < CP_TWO_BYTE) begin
      natural_n = 2'd1;
    end else if (cmd_i.code < CP_THREE_BYTE) begin
      natural_n = 2'd2;
    end else begin
      natural_n = 2'd3;
    end
  end

  // a sequence goes out whole or not at all
  assign fits = (wc_ext + (LenW + 1)'(natural_n)) <= {1'b0, max_q};
  assign nc_first = fits ? natural_n : 2'd0;

  always_comb begin
    case (cmd_i.tail)
      TAIL_RAW:                           te_first = (wc_ext + (LenW + 1)'(nc_first))
                                                     < {1'b0, max_q};
      TAIL_DONE, TAIL_UNTERM, TAIL_NOTSTR: te_first = 1'b1;
      default:                            te_first = 1'b0;
    endcase
  end

  assign nc = (step_q == 2'd0) ? nc_first : nc_q;
  assign te = (step_q == 2'd0) ? te_first : te_q;

  assign go = cmd_valid_i && !res_full_i;
  assign emit_code = step_q < nc;
  assign emit_tail = !emit_code && te;
  assign last = emit_code ? ((step_q == nc - 2'd1) && !te) : 1'b1;
  assign finish = !(emit_code && !last);

  always_comb begin
    unique case (natural_n)
      2'd1: code_byte = cmd_i.code[7:0];
      2'd2: code_byte = (step_q == 2'd0) ? {3'b110, cmd_i.code[10:6]}
                                         : {2'b10, cmd_i.code[5:0]};
      2'd3: begin
        if (step_q == 2'd0) begin
          code_byte = {4'b1110, cmd_i.code[15:12]};
        end else if (step_q == 2'd1) begin
          code_byte = {2'b10, cmd_i.code[11:6]};
        end else begin
          code_byte = {2'b10, cmd_i.code[5:0]};
        end
      end
      default: code_byte = cmd_i.code[7:0];
    endcase
  end

  always_comb begin
    res.kind = KIND_DATA;
    res.out_byte = code_byte;
    res.out_length = wc_q + LenW'(1);
    res.last = last;
    wc_d = wc_q;
    if (emit_code) begin
      wc_d = wc_q + LenW'(1);
    end else begin
      case (cmd_i.tail)
        TAIL_RAW: begin
          res.out_byte = cmd_i.tail_byte;
          wc_d = wc_q + LenW'(1);
        end
        TAIL_DONE: begin
          res.kind = KIND_DONE;
          res.out_byte = '0;
          res.out_length = wc_q;
        end
        TAIL_UNTERM: begin
          res.kind = KIND_UNTERM;
          res.out_byte = '0;
          res.out_length = wc_q;
        end
        TAIL_NOTSTR: begin
          res.kind = KIND_NOTSTR;
          res.out_byte = '0;
          res.out_length = '0;
        end
        TAIL_START: begin
          wc_d = '0;
        end
        default: begin
          wc_d = wc_q;
        end
      endcase
      if (!emit_tail && cmd_i.tail == TAIL_RAW) begin
        wc_d = wc_q;
      end
    end
    step_d = finish ? 2'd0 : step_q + 2'd1;
  end

  assign res_o = res;
  assign res_push_o = go && (emit_code || emit_tail);
  assign cmd_pop_o = go && finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxOutReset;
      wc_q <= '0;
      step_q <= '0;
      nc_q <= '0;
      te_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_q <= cfg_data_i;
      end
      if (go) begin
        wc_q <= wc_d;
        step_q <= step_d;
        if (step_q == 2'd0) begin
          nc_q <= nc_first;
          te_q <= te_first;
        end
      end
    end
  end

endmodule

@@ hdl/jsu_checker.sv @@
// port-level checks of the json string unescaper
`timescale 1ns / 1ps
module jsu_checker import jsu_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             empty,
  input logic             pop,
  input logic [KindW-1:0] kind_o,
  input logic [ByteW-1:0] out_byte_o,
  input logic [LenW-1:0]  out_length_o,
  input logic             last_o
);

  // status words always close the results of their input word
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o != KIND_DATA |-> last_o)
    else $error("status word without last");

  a_notstr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o == KIND_NOTSTR |-> out_length_o == '0 && out_byte_o == '0)
    else $error("not-a-string word carries data");

  a_data_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o == KIND_DATA |-> out_length_o != '0)
    else $error("data word with zero length");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(kind_o) && $stable(out_byte_o) &&
    $stable(out_length_o) && $stable(last_o))
    else $error("waiting result changed");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .kind_o       (kind_o),
  .out_byte_o   (out_byte_o),
  .out_length_o (out_length_o),
  .last_o       (last_o)
);

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the json string unescaper
`timescale 1ns / 1ps
module tb_top;
  import jsu_pkg::*;

  // character codes seen by the decoder
  localparam logic [7:0] CH_EOT = 8'h00;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] ESC_B = "b";
  localparam logic [7:0] ESC_F = "f";
  localparam logic [7:0] ESC_N = "n";
  localparam logic [7:0] ESC_R = "r";
  localparam logic [7:0] ESC_T = "t";
  localparam logic [7:0] ESC_U = "u";

  localparam logic [7:0] UTF_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF_CONT = 8'h80;

  localparam int PLAN_WORDS = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 5000;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_STR,
    PH_ESC,
    PH_HEX
  } str_phase_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             full;
  logic [ByteW-1:0] text_byte_i = '0;
  logic             empty;
  logic             pop = 1'b0;
  logic [KindW-1:0] kind_o;
  logic [ByteW-1:0] out_byte_o;
  logic [LenW-1:0]  out_length_o;
  logic             last_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [LenW-1:0]  cfg_data_i = '0;

  json_string_unescape uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .text_byte_i (text_byte_i),
    .empty       (empty),
    .pop         (pop),
    .kind_o      (kind_o),
    .out_byte_o  (out_byte_o),
    .out_length_o(out_length_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder state mirrored by the testbench
  logic [LenW-1:0]  lim = MaxOutReset;
  str_phase_e       ph = PH_IDLE;
  logic [CodeW-1:0] cp16 = '0;
  logic [1:0]       ndig = '0;
  logic [LenW-1:0]  wcount = '0;

  result_t    fresh[$];
  result_t    decoded_q[$];
  logic [7:0] text_q[$];
  logic [7:0] plan_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int mismatches = 0;
  int words_in = 0;
  int results_checked = 0;
  int limit_writes = 0;
  int stall_cycles = 0;

  function automatic int hex_of(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic void add_result(input logic [KindW-1:0] k, input logic [7:0] b,
                                     input logic [LenW-1:0] len);
    result_t r;
    r.kind = k;
    r.out_byte = b;
    r.out_length = len;
    r.last = 1'b0;
    fresh.push_back(r);
  endfunction

  function automatic void emit_data(input logic [7:0] b);
    wcount = wcount + 9'd1;
    add_result(KIND_DATA, b, wcount);
  endfunction

  // a multi-byte sequence goes out whole or not at all
  function automatic void emit_code(input logic [CodeW-1:0] cp);
    if (cp < CP_TWO_BYTE) begin
      if (int'(wcount) + 1 <= int'(lim)) emit_data(cp[7:0]);
    end else if (cp < CP_THREE_BYTE) begin
      if (int'(wcount) + 2 <= int'(lim)) begin
        emit_data(UTF_LEAD2 | {3'b000, cp[10:6]});
        emit_data(UTF_CONT | {2'b00, cp[5:0]});
      end
    end else if (int'(wcount) + 3 <= int'(lim)) begin
      emit_data(UTF_LEAD3 | {4'b0000, cp[15:12]});
      emit_data(UTF_CONT | {2'b00, cp[11:6]});
      emit_data(UTF_CONT | {2'b00, cp[5:0]});
    end
  endfunction

  function automatic void in_string(input logic [7:0] b);
    if (b == CH_EOT) begin
      add_result(KIND_UNTERM, 8'h00, wcount);
      ph = PH_IDLE;
    end else if (b == CH_QUOTE) begin
      add_result(KIND_DONE, 8'h00, wcount);
      ph = PH_IDLE;
    end else if (b == CH_BSLASH) begin
      ph = PH_ESC;
    end else if (wcount < lim) begin
      emit_data(b);
    end
  endfunction

  function automatic void unescape_word(input logic [7:0] b);
    int h;
    logic [7:0] mapped;
    result_t r;
    fresh.delete();
    case (ph)
      PH_IDLE: begin
        if (!(b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) begin
          if (b == CH_QUOTE) begin
            wcount = '0;
            ph = PH_STR;
          end else begin
            add_result(KIND_NOTSTR, 8'h00, '0);
          end
        end
      end
      PH_STR: in_string(b);
      PH_ESC: begin
        if (b == CH_EOT) begin
          add_result(KIND_UNTERM, 8'h00, wcount);
          ph = PH_IDLE;
        end else if (b == ESC_U) begin
          cp16 = '0;
          ndig = '0;
          ph = PH_HEX;
        end else begin
          case (b)
            ESC_N: mapped = CH_LF;
            ESC_R: mapped = CH_CR;
            ESC_T: mapped = CH_TAB;
            ESC_B: mapped = CH_BS;
            ESC_F: mapped = CH_FF;
            default: mapped = b;
          endcase
          if (wcount < lim) emit_data(mapped);
          ph = PH_STR;
        end
      end
      default: begin
        h = hex_of(b);
        if (b == CH_EOT) begin
          emit_code(cp16);
          add_result(KIND_UNTERM, 8'h00, wcount);
          ph = PH_IDLE;
        end else if (h < 0) begin
          // short escape: replacement character, then the byte handled as in the string
          emit_code(CP_REPLACEMENT);
          ph = PH_STR;
          in_string(b);
        end else begin
          cp16 = {cp16[11:0], h[3:0]};
          if (ndig == 2'd3) begin
            emit_code(cp16);
            ndig = '0;
            ph = PH_STR;
          end else begin
            ndig = ndig + 2'd1;
          end
        end
      end
    endcase
    if (fresh.size() != 0) begin
      r = fresh.pop_back();
      r.last = 1'b1;
      fresh.push_back(r);
    end
    foreach (fresh[i]) decoded_q.push_back(fresh[i]);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return "0" + v;
    return ($urandom_range(1) ? "a" : "A") + v - 8'd10;
  endfunction

  // one quoted string, mostly well formed, with random content
  function automatic void add_string();
    int len;
    logic [7:0] b;
    logic [15:0] cp;
    repeat ($urandom_range(0, 2))
      plan_q.push_back(($urandom_range(5) == 5) ? CH_SPACE
                                                : CH_TAB + 8'($urandom_range(0, 4)));
    plan_q.push_back(CH_QUOTE);
    len = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 6);
    repeat (len) begin
      case ($urandom_range(9))
        5, 6: begin
          plan_q.push_back(CH_BSLASH);
          case ($urandom_range(8))
            0: b = CH_QUOTE;
            1: b = CH_BSLASH;
            2: b = CH_SLASH;
            3: b = ESC_N;
            4: b = ESC_R;
            5: b = ESC_T;
            6: b = ESC_B;
            7: b = ESC_F;
            default: begin
              do b = 8'($urandom_range(1, 255)); while (b == ESC_U);
            end
          endcase
          plan_q.push_back(b);
        end
        7, 8: begin
          case ($urandom_range(3))
            0: cp = 16'($urandom_range(0, 16'h007F));
            1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
            2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            default: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
          endcase
          plan_q.push_back(CH_BSLASH);
          plan_q.push_back(ESC_U);
          for (int k = 3; k >= 0; k--) plan_q.push_back(hex_char(cp[4*k +: 4]));
        end
        9: begin
          plan_q.push_back(CH_BSLASH);
          plan_q.push_back(ESC_U);
          repeat ($urandom_range(0, 3))
            plan_q.push_back(hex_char(4'($urandom_range(0, 15))));
          if ($urandom_range(3) == 0) b = CH_QUOTE;
          else do b = 8'($urandom_range(1, 255)); while (hex_of(b) >= 0);
          plan_q.push_back(b);
        end
        default: begin
          do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
          plan_q.push_back(b);
        end
      endcase
    end
    case ($urandom_range(19))
      0: plan_q.push_back(CH_EOT);
      1: begin
        plan_q.push_back(CH_BSLASH);
        plan_q.push_back(CH_EOT);
      end
      2: begin
        plan_q.push_back(CH_BSLASH);
        plan_q.push_back(ESC_U);
        repeat ($urandom_range(0, 3))
          plan_q.push_back(hex_char(4'($urandom_range(0, 15))));
        plan_q.push_back(CH_EOT);
      end
      default: plan_q.push_back(CH_QUOTE);
    endcase
  endfunction

  // sender: offers the oldest pending word at the falling edge
  always @(negedge clk_i) begin
    push <= rst_ni && (text_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
    text_byte_i <= (text_q.size() != 0) ? text_q[0] : CH_EOT;
  end

  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      unescape_word(text_byte_i);
      void'(text_q.pop_front());
      words_in++;
    end
  end

  // receiver: random pops, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (decoded_q.size() == 0) begin
        $error("result with nothing outstanding: kind %0d byte %0h length %0d",
               kind_o, out_byte_o, out_length_o);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        results_checked++;
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          mismatches++;
        end
        if (out_byte_o !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_byte_o);
          mismatches++;
        end
        if (out_length_o !== want.out_length) begin
          $error("out_length: expected %0d, got %0d", want.out_length, out_length_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress, %0d words queued, %0d results outstanding",
                 text_q.size(), decoded_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // every word sent and every result back, then let the pipeline settle
  task automatic wait_drained();
    while (text_q.size() != 0 || decoded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LenW-1:0] v);
    wait_drained();
    @(negedge clk_i);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    lim = v;
    limit_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int chunk;
    logic [LenW-1:0] lim_val;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    send_idle_pct = 24;
    recv_idle_pct = 76;

    // escapes, surrogate, short \u, end of text cases; ends inside an open string
    text_q = {CH_SPACE, CH_QUOTE, 8'hFF, CH_BSLASH, CH_QUOTE,
              CH_BSLASH, ESC_U, "D", "8", "0", "0",
              CH_BSLASH, ESC_U, "4", "g", CH_QUOTE,
              "x", CH_EOT,
              CH_QUOTE, CH_BSLASH, ESC_U, "7", CH_EOT,
              CH_QUOTE, CH_BSLASH, CH_EOT,
              CH_QUOTE, "A"};

    while (plan_q.size() < PLAN_WORDS) begin
      if ($urandom_range(99) < 85) add_string();
      else repeat ($urandom_range(1, 3)) plan_q.push_back(8'($urandom_range(0, 255)));
    end
    chunk = (plan_q.size() + 5) / 6;

    for (int p = 0; p < 6; p++) begin
      // first write lands inside the open string and lowers the limit
      case (p)
        0: lim_val = 9'd1;
        1: lim_val = 9'd511;
        2: lim_val = 9'd0;
        3: lim_val = 9'd5;
        4: lim_val = 9'd255;
        default: lim_val = 9'd3;
      endcase
      write_limit(lim_val);
      if (p == 2) begin
        send_idle_pct = 76;
        recv_idle_pct = 24;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked++;
      end
      repeat (chunk) if (plan_q.size() != 0) text_q.push_back(plan_q.pop_front());
    end

    wait_drained();
    if (decoded_q.size() != 0) begin
      $error("%0d results never arrived", decoded_q.size());
      mismatches++;
    end
    $display("run: %0d text words decoded, %0d results compared, %0d limit writes",
             words_in, results_checked, limit_writes);
    $display("limits 0 to 511, idle and stall patterns on both sides, one full back-pressure");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
